// ===== rtl/dvfs_level_lock_arbiter_assert.svh =====
// Assertion macros for the level-lock arbiter.
// Empty bodies when SYNTHESIS is defined; uses clk and rst_n of the including module.
`ifndef DVFS_LEVEL_LOCK_ARBITER_ASSERT_SVH
`define DVFS_LEVEL_LOCK_ARBITER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DLLA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvfs_level_lock_arbiter: same-cycle check failed");
// next-cycle implication
`define DLLA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvfs_level_lock_arbiter: next-cycle check failed");
`else
`define DLLA_ASSERT_IMP(lbl, ante, cons)
`define DLLA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/dlla_pkg.sv =====
// Shared types, constants and vote functions for the level-lock arbiter.
// No dependencies.
package dlla_pkg;

    localparam int LOCK_SLOTS_DEF  = 4;
    localparam int LEVEL_NUM_DEF   = 16;
    localparam int LEVEL_W         = 4;
    localparam int VOTE_W          = 5;
    localparam int SLOT_W          = 2;
    localparam int CFG_IDX_W       = 2;

    typedef logic [LEVEL_W-1:0]        level_t;
    typedef logic signed [VOTE_W-1:0]  vote_t;
    typedef logic [SLOT_W-1:0]         slot_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    localparam vote_t VOTE_UNSET = -5'sd1;

    localparam cfg_idx_t CFG_SLOWEST = 2'd0;
    localparam cfg_idx_t CFG_FASTEST = 2'd1;

    typedef struct packed {
        vote_t vmin;
        vote_t vmax;
    } entry_t;

    localparam entry_t ENTRY_UNSET = '{vmin: VOTE_UNSET, vmax: VOTE_UNSET};

    typedef struct packed {
        level_t slowest;
        level_t fastest;
    } limits_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SWEEP,
        ST_CLAMP
    } state_t;

    function automatic logic vote_reject(vote_t vmin, vote_t vmax);
        return !vmin[VOTE_W-1] && !vmax[VOTE_W-1] && (vmin < vmax);
    endfunction

    function automatic entry_t update_entry(entry_t cur, vote_t vmin, vote_t vmax,
                                            level_t slowest, level_t fastest);
        vote_t s_v;
        vote_t f_v;
        vote_t cmin;
        vote_t cmax;
        entry_t nxt;
        s_v  = vote_t'({1'b0, slowest});
        f_v  = vote_t'({1'b0, fastest});
        cmin = cur.vmin;
        cmax = cur.vmax;
        if (!vmin[VOTE_W-1])
        begin
            cmin = (vmin < s_v) ? vmin : s_v;
            if (cmax > vmin)
                cmax = VOTE_UNSET;
        end
        if (!vmax[VOTE_W-1])
        begin
            cmax = (vmax > f_v) ? vmax : f_v;
            if (cmin < vmax)
                cmin = VOTE_UNSET;
        end
        if (cmin == s_v)
            cmin = VOTE_UNSET;
        if (cmax == f_v)
            cmax = VOTE_UNSET;
        nxt.vmin = cmin;
        nxt.vmax = cmax;
        return nxt;
    endfunction

    function automatic limits_t sweep_step(limits_t acc, entry_t e);
        limits_t nxt;
        nxt = acc;
        if (!e.vmin[VOTE_W-1])
        begin
            if (e.vmin[LEVEL_W-1:0] < nxt.slowest)
                nxt.slowest = e.vmin[LEVEL_W-1:0];
            if (nxt.slowest < nxt.fastest)
                nxt.fastest = nxt.slowest;
        end
        if (!e.vmax[VOTE_W-1])
        begin
            if (e.vmax[LEVEL_W-1:0] > nxt.fastest)
                nxt.fastest = e.vmax[LEVEL_W-1:0];
            if (nxt.fastest > nxt.slowest)
                nxt.slowest = nxt.fastest;
        end
        return nxt;
    endfunction

    function automatic level_t clamp_level(level_t lvl, limits_t lim);
        level_t t;
        t = (lvl < lim.fastest) ? lim.fastest : lvl;
        t = (t > lim.slowest) ? lim.slowest : t;
        return t;
    endfunction

endpackage

// ===== rtl/dlla_req_if.sv =====
// Request channel: slot, votes and current level.
// Depends on dlla_pkg.
interface dlla_req_if;
    logic                 valid;
    logic                 ready;
    dlla_pkg::slot_t      slot;
    dlla_pkg::vote_t      vote_min;
    dlla_pkg::vote_t      vote_max;
    dlla_pkg::level_t     current_level;

    modport source (output valid, output slot, output vote_min, output vote_max,
                    output current_level, input ready);
    modport sink   (input valid, input slot, input vote_min, input vote_max,
                    input current_level, output ready);
endinterface

// ===== rtl/dlla_rsp_if.sv =====
// Result channel: reject flag, effective limits and target level.
// Depends on dlla_pkg.
interface dlla_rsp_if;
    logic                 valid;
    logic                 ready;
    logic                 rejected;
    dlla_pkg::level_t     limit_slowest;
    dlla_pkg::level_t     limit_fastest;
    dlla_pkg::level_t     target_level;

    modport source (output valid, output rejected, output limit_slowest,
                    output limit_fastest, output target_level, input ready);
    modport sink   (input valid, input rejected, input limit_slowest,
                    input limit_fastest, input target_level, output ready);
endinterface

// ===== rtl/dlla_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on dlla_pkg.
interface dlla_cfg_if;
    logic                 valid;
    logic                 ready;
    dlla_pkg::cfg_idx_t   index;
    dlla_pkg::level_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dvfs_level_lock_arbiter.sv =====
// Level-lock arbiter top level; uses dlla_pkg, the channel interfaces and the assert header.
// A request item passes through MOD, SWEEP and CLAMP to the output register; a rejected
// item skips SWEEP. No new item is taken until the previous one leaves CLAMP, and the
// single-read slot memory sweep visits every slot in turn.
// A new item is taken while the previous result waits in the output register.
// Reset: bounds and limits to their defaults, all slots unset through per-slot valid flops.
`include "dvfs_level_lock_arbiter_assert.svh"

module dvfs_level_lock_arbiter #(
    parameter int LOCK_SLOTS = dlla_pkg::LOCK_SLOTS_DEF,
    parameter int LEVEL_NUM  = dlla_pkg::LEVEL_NUM_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    dlla_req_if.sink     req,
    dlla_rsp_if.source   rsp,
    dlla_cfg_if.sink     cfg
);

    localparam int ADDR_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(LOCK_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(LOCK_SLOTS);
    localparam dlla_pkg::level_t SLOWEST_RST =
        dlla_pkg::level_t'((LEVEL_NUM - 1) % (2 ** dlla_pkg::LEVEL_W));
    localparam dlla_pkg::level_t FASTEST_RST = '0;

    dlla_pkg::state_t  state_reg, state_next;

    dlla_pkg::level_t  slowest_level_reg, fastest_level_reg;
    dlla_pkg::limits_t eff_reg, eff_next;
    dlla_pkg::limits_t acc_reg, acc_next;

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              in_range_reg, in_range_next;
    dlla_pkg::vote_t   vote_min_reg, vote_min_next;
    dlla_pkg::vote_t   vote_max_reg, vote_max_next;
    dlla_pkg::level_t  level_reg, level_next;
    logic              rej_reg, rej_next;

    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              pend_reg, pend_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic              out_rejected_reg, out_rejected_next;
    dlla_pkg::limits_t out_lim_reg, out_lim_next;
    dlla_pkg::level_t  out_target_reg, out_target_next;

    dlla_pkg::entry_t  mem [LOCK_SLOTS];
    logic [LOCK_SLOTS-1:0] entry_valid_reg;
    dlla_pkg::entry_t  rd_data_reg;
    logic              rd_hit_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] rd_addr;
    dlla_pkg::entry_t  wr_data;
    dlla_pkg::entry_t  rd_entry;

    logic [31:0]       slot_wide;
    logic              req_reject;
    logic              sweep_done;
    logic              out_free;
    dlla_pkg::limits_t step_lim;

    logic              upd_write_ok;
    logic              lim_ordered;
    logic              target_ok;

    assign slot_wide  = 32'(req.slot);
    assign req_reject = dlla_pkg::vote_reject(vote_min_reg, vote_max_reg);
    assign rd_entry   = rd_hit_reg ? rd_data_reg : dlla_pkg::ENTRY_UNSET;
    assign step_lim   = dlla_pkg::sweep_step(acc_reg, rd_entry);
    assign sweep_done = (state_reg == dlla_pkg::ST_SWEEP) && (issue_cnt_reg == SLOT_END)
                        && pend_reg;
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign wr_data    = dlla_pkg::update_entry(rd_entry, vote_min_reg, vote_max_reg,
                                               slowest_level_reg, fastest_level_reg);

    assign req.ready         = (state_reg == dlla_pkg::ST_IDLE);
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.rejected      = out_rejected_reg;
    assign rsp.limit_slowest = out_lim_reg.slowest;
    assign rsp.limit_fastest = out_lim_reg.fastest;
    assign rsp.target_level  = out_target_reg;

    assign upd_write_ok = (state_reg == dlla_pkg::ST_MOD) && in_range_reg && !req_reject;
    assign lim_ordered  = rsp.valid && (rsp.limit_fastest <= rsp.limit_slowest);
    assign target_ok    = (rsp.target_level >= rsp.limit_fastest)
                          && (rsp.target_level <= rsp.limit_slowest);

    // slot memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= wr_data;
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= entry_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= '0;
        else if (mem_we)
            entry_valid_reg[addr_reg] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slowest_level_reg <= SLOWEST_RST;
            fastest_level_reg <= FASTEST_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dlla_pkg::CFG_SLOWEST: slowest_level_reg <= cfg.data;
                dlla_pkg::CFG_FASTEST: fastest_level_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlla_pkg::ST_IDLE;
            eff_reg       <= '{slowest: SLOWEST_RST, fastest: FASTEST_RST};
            rsp_valid_reg <= 1'b0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eff_reg       <= eff_next;
            rsp_valid_reg <= rsp_valid_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        addr_reg         <= addr_next;
        in_range_reg     <= in_range_next;
        vote_min_reg     <= vote_min_next;
        vote_max_reg     <= vote_max_next;
        level_reg        <= level_next;
        rej_reg          <= rej_next;
        out_rejected_reg <= out_rejected_next;
        out_lim_reg      <= out_lim_next;
        out_target_reg   <= out_target_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dlla_pkg::ST_IDLE:
                if (req.valid)
                    state_next = dlla_pkg::ST_MOD;
            dlla_pkg::ST_MOD:
                state_next = req_reject ? dlla_pkg::ST_CLAMP : dlla_pkg::ST_SWEEP;
            dlla_pkg::ST_SWEEP:
                if (sweep_done)
                    state_next = dlla_pkg::ST_CLAMP;
            dlla_pkg::ST_CLAMP:
                if (out_free)
                    state_next = dlla_pkg::ST_IDLE;
            default:
                state_next = dlla_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        eff_next          = eff_reg;
        acc_next          = acc_reg;
        addr_next         = addr_reg;
        in_range_next     = in_range_reg;
        vote_min_next     = vote_min_reg;
        vote_max_next     = vote_max_reg;
        level_next        = level_reg;
        rej_next          = rej_reg;
        issue_cnt_next    = issue_cnt_reg;
        pend_next         = 1'b0;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        out_rejected_next = out_rejected_reg;
        out_lim_next      = out_lim_reg;
        out_target_next   = out_target_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        rd_addr           = issue_cnt_reg[ADDR_W-1:0];
        case (state_reg)
            dlla_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    addr_next     = slot_wide[ADDR_W-1:0];
                    in_range_next = slot_wide < 32'(LOCK_SLOTS);
                    vote_min_next = req.vote_min;
                    vote_max_next = req.vote_max;
                    level_next    = req.current_level;
                    mem_re        = 1'b1;
                    rd_addr       = slot_wide[ADDR_W-1:0];
                end
            end
            dlla_pkg::ST_MOD:
            begin
                rej_next       = req_reject;
                mem_we         = !req_reject && in_range_reg;
                issue_cnt_next = '0;
                acc_next       = '{slowest: slowest_level_reg, fastest: fastest_level_reg};
            end
            dlla_pkg::ST_SWEEP:
            begin
                if (issue_cnt_reg != SLOT_END)
                begin
                    mem_re         = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                end
                if (pend_reg)
                    acc_next = step_lim;
                if (sweep_done)
                    eff_next = step_lim;
            end
            dlla_pkg::ST_CLAMP:
            begin
                if (out_free)
                begin
                    rsp_valid_next    = 1'b1;
                    out_rejected_next = rej_reg;
                    out_lim_next      = eff_reg;
                    out_target_next   = dlla_pkg::clamp_level(level_reg, eff_reg);
                end
            end
            default: ;
        endcase
    end

    `DLLA_ASSERT_IMP(a_busy_not_ready, state_reg != dlla_pkg::ST_IDLE, !req.ready)
    `DLLA_ASSERT_IMP(a_write_only_on_update, mem_we, upd_write_ok)
    `DLLA_ASSERT_NXT(a_sweep_to_clamp, sweep_done, state_reg == dlla_pkg::ST_CLAMP)
    `DLLA_ASSERT_IMP(a_target_in_limits, lim_ordered, target_ok)

endmodule
